>>> design/pssb_pkg.sv
// ----------------------------------------------------------------------------
// pssb_pkg
// Shared types and codes for the polygon scanline span builder.
// ----------------------------------------------------------------------------
package pssb_pkg;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SPAN = 1'b1;

  typedef struct packed {
    logic clr;
    logic pt;
    logic rd;
  } pssb_mem_cmd_t;

endpackage

>>> design/pssb_div.sv
// ----------------------------------------------------------------------------
// pssb_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pssb_div #(
  parameter int NW = 25,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNW = $clog2(NW + 1);

  logic           busy_r;
  logic           done_r;
  logic [CNW-1:0] cnt_r;
  logic [DW-1:0]  rem_r;
  logic [NW-1:0]  quo_r;
  logic [DW-1:0]  dvs_r;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/pssb_span_store.sv
// ----------------------------------------------------------------------------
// pssb_span_store
// Per-row left/right extent memory with read-modify-write merge and
// forwarding of the previous write.
// ----------------------------------------------------------------------------
module pssb_span_store #(
  parameter int SCREEN_SIZE = 512,
  parameter int CW          = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pssb_pkg::pssb_mem_cmd_t cmd,
  input  logic [CW-1:0]          addr,
  input  logic [CW-1:0]          px,
  output logic [CW-1:0]          q_left,
  output logic [CW-1:0]          q_right
);
  import pssb_pkg::*;

  localparam logic [CW-1:0] SMAX = CW'(SCREEN_SIZE - 1);

  logic [2*CW-1:0] mem [SCREEN_SIZE];
  logic [2*CW-1:0] q_r;
  logic            pt_v_r;
  logic [CW-1:0]   addr_r;
  logic [CW-1:0]   px_r;
  logic            lw_v_r;
  logic [CW-1:0]   lw_addr_r;
  logic [2*CW-1:0] lw_data_r;
  logic [2*CW-1:0] base;
  logic [CW-1:0]   m_left;
  logic [CW-1:0]   m_right;
  logic [2*CW-1:0] merged;

  always_comb begin
    base    = (lw_v_r && lw_addr_r == addr_r) ? lw_data_r : q_r;
    m_left  = (px_r < base[2*CW-1:CW]) ? px_r : base[2*CW-1:CW];
    m_right = (px_r > base[CW-1:0]) ? px_r : base[CW-1:0];
    merged  = {m_left, m_right};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_v_r <= 1'b0;
      lw_v_r <= 1'b0;
    end else begin
      pt_v_r <= cmd.pt;
      lw_v_r <= pt_v_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr;
    px_r      <= px;
    lw_addr_r <= addr_r;
    lw_data_r <= merged;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[addr] <= {SMAX, CW'(0)};
    end else if (pt_v_r) begin
      mem[addr_r] <= merged;
    end
    if (cmd.pt || cmd.rd) begin
      q_r <= mem[addr];
    end
  end

  assign q_left  = q_r[2*CW-1:CW];
  assign q_right = q_r[CW-1:0];

endmodule

>>> design/polygon_scanline_span_builder.sv
// ----------------------------------------------------------------------------
// polygon_scanline_span_builder
// Loads polygon vertices, walks the closed edges with DDA interpolation and
// serves one span row per request.
// ----------------------------------------------------------------------------
// The closing vertex stalls the input while the rows from the lowest to the
// highest are cleared in the span memory and the first vertex is fetched.
// Then, for each edge, the next vertex is read, set up and serially divided
// for the minor-axis step, and the edge is walked at one point per cycle
// through the span memory read-modify-write, followed by a final drain state.
// A span request passes through the registered read of the span memory and
// then into the output register.
// ----------------------------------------------------------------------------
module polygon_scanline_span_builder #(
  parameter int SCREEN_SIZE  = 512,
  parameter int MAX_VERTICES = 8,
  parameter int FRAC_BITS    = 16,
  localparam int CW          = $clog2(SCREEN_SIZE)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_action,
  input  logic [CW-1:0] in_vertex_x,
  input  logic [CW-1:0] in_vertex_y,
  input  logic          in_vertex_last,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [CW-1:0] out_row_y,
  output logic [CW-1:0] out_left_x,
  output logic [CW-1:0] out_right_x,
  output logic          out_last_row
);
  import pssb_pkg::*;

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int AW  = CW + FRAC_BITS + 2;
  localparam int NW  = CW + FRAC_BITS;
  localparam logic [CW-1:0] SMAX = CW'(SCREEN_SIZE - 1);
  localparam logic signed [AW-1:0] HALF = AW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [AW-1:0] ONE  = AW'(64'd1 << FRAC_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_RDB   = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_WALK  = 3'd6;
  localparam logic [2:0] S_DRAIN = 3'd7;

  function automatic logic [CW-1:0] sat_coord(input logic [CW-1:0] v);
    return (v > SMAX) ? SMAX : v;
  endfunction

  function automatic logic [CW-1:0] fx_round(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    logic [AW-1:0]        t;
    r = v + HALF;
    t = AW'(r) >> FRAC_BITS;
    if (r < 0) begin
      return '0;
    end else if (t > AW'(SCREEN_SIZE - 1)) begin
      return SMAX;
    end else begin
      return t[CW-1:0];
    end
  endfunction

  logic [2:0]      state_r;
  logic [2*CW-1:0] vmem [MAX_VERTICES];
  logic [2*CW-1:0] vq_r;
  logic [VCW-1:0]  vcount_r;
  logic [VCW-1:0]  nvert_r;
  logic [VIW-1:0]  vidx_r;
  logic [CW-1:0]   low_r;
  logic [CW-1:0]   high_r;
  logic            ready_r;
  logic [CW-1:0]   cur_row_r;
  logic [CW-1:0]   clr_r;
  logic [CW-1:0]   ax_r;
  logic [CW-1:0]   ay_r;
  logic [CW-1:0]   bx_r;
  logic [CW-1:0]   by_r;
  logic            xmaj_r;
  logic            sgnx_r;
  logic            sgny_r;
  logic [CW-1:0]   maj_r;
  logic [CW-1:0]   cnt_r;
  logic signed [AW-1:0] cx_r;
  logic signed [AW-1:0] cy_r;
  logic signed [AW-1:0] sx_r;
  logic signed [AW-1:0] sy_r;
  logic            pend_r;
  logic [CW-1:0]   pend_row_r;
  logic            pend_last_r;
  logic            out_valid_r;
  logic [CW-1:0]   out_row_r;
  logic [CW-1:0]   out_left_r;
  logic [CW-1:0]   out_right_r;
  logic            out_last_r;

  logic            in_acc;
  logic [CW-1:0]   ld_x;
  logic [CW-1:0]   ld_y;
  logic [VCW-1:0]  cnt_eff;
  logic            room;
  logic [VCW-1:0]  n_after;
  logic [CW-1:0]   low_new;
  logic [CW-1:0]   high_new;
  logic [CW-1:0]   bx;
  logic [CW-1:0]   by;
  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic [CW-1:0]   adx;
  logic [CW-1:0]   ady;
  logic            xmaj;
  logic [CW-1:0]   maj;
  logic [CW-1:0]   mnr;
  logic            div_start;
  logic            div_done;
  logic [NW-1:0]   div_q;
  logic signed [AW-1:0] qstep;
  logic signed [AW-1:0] mstep;
  logic [CW-1:0]   px;
  logic [CW-1:0]   py;
  pssb_mem_cmd_t   cmd;
  logic [CW-1:0]   m_addr;
  logic [CW-1:0]   q_left;
  logic [CW-1:0]   q_right;

  assign in_stall = (state_r != S_IDLE) || pend_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    ld_x    = sat_coord(in_vertex_x);
    ld_y    = sat_coord(in_vertex_y);
    cnt_eff = ready_r ? '0 : vcount_r;
    room    = cnt_eff < VCW'(MAX_VERTICES);
    n_after = room ? cnt_eff + VCW'(1) : cnt_eff;
    low_new  = low_r;
    high_new = high_r;
    if (room) begin
      if (cnt_eff == '0) begin
        low_new  = ld_y;
        high_new = ld_y;
      end else begin
        low_new  = (ld_y < low_r) ? ld_y : low_r;
        high_new = (ld_y > high_r) ? ld_y : high_r;
      end
    end
  end

  always_comb begin
    bx   = vq_r[2*CW-1:CW];
    by   = vq_r[CW-1:0];
    dx   = $signed({1'b0, bx}) - $signed({1'b0, ax_r});
    dy   = $signed({1'b0, by}) - $signed({1'b0, ay_r});
    adx  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    xmaj = adx >= ady;
    maj  = xmaj ? adx : ady;
    mnr  = xmaj ? ady : adx;
    div_start = (state_r == S_SETUP);
  end

  pssb_div #(.NW(NW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mnr, FRAC_BITS'(0)}),
    .divisor  ((maj == '0) ? CW'(1) : maj),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    qstep = $signed(AW'(div_q));
    mstep = (maj_r == '0) ? '0 : ONE;
    px    = fx_round(cx_r);
    py    = fx_round(cy_r);
  end

  always_comb begin
    cmd    = '0;
    m_addr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_action == ACT_SPAN && ready_r) begin
          cmd.rd = 1'b1;
          m_addr = cur_row_r;
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        m_addr  = clr_r;
      end
      S_WALK: begin
        if (py >= low_r && py <= high_r) begin
          cmd.pt = 1'b1;
          m_addr = py;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  pssb_span_store #(.SCREEN_SIZE(SCREEN_SIZE), .CW(CW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .addr    (m_addr),
    .px      (px),
    .q_left  (q_left),
    .q_right (q_right)
  );

  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_LOAD && room) begin
      vmem[cnt_eff[VIW-1:0]] <= {ld_x, ld_y};
    end
    vq_r <= vmem[vidx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      nvert_r     <= '0;
      vidx_r      <= '0;
      low_r       <= '0;
      high_r      <= '0;
      ready_r     <= 1'b0;
      cur_row_r   <= '0;
      clr_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= in_acc && in_action == ACT_SPAN && ready_r;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_action == ACT_LOAD) begin
            ready_r <= 1'b0;
            low_r   <= low_new;
            high_r  <= high_new;
            if (in_vertex_last) begin
              nvert_r  <= n_after;
              vcount_r <= '0;
              vidx_r   <= '0;
              clr_r    <= low_new;
              state_r  <= S_CLEAR;
            end else begin
              vcount_r <= n_after;
            end
          end else if (in_acc && ready_r) begin
            if (cur_row_r >= high_r) begin
              ready_r <= 1'b0;
            end else begin
              cur_row_r <= cur_row_r + CW'(1);
            end
          end
        end
        S_CLEAR: begin
          if (clr_r == high_r) begin
            state_r <= S_FIRST;
          end else begin
            clr_r <= clr_r + CW'(1);
          end
        end
        S_FIRST: begin
          vidx_r  <= (nvert_r > VCW'(1)) ? VIW'(1) : '0;
          state_r <= S_RDB;
        end
        S_RDB: begin
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          cnt_r   <= maj;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            if (vidx_r == '0) begin
              state_r <= S_DRAIN;
            end else begin
              vidx_r  <= (VCW'(vidx_r) + VCW'(1) == nvert_r) ? '0 : vidx_r + VIW'(1);
              state_r <= S_RDB;
            end
          end
        end
        S_DRAIN: begin
          ready_r   <= 1'b1;
          cur_row_r <= low_r;
          state_r   <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIRST) begin
      ax_r <= vq_r[2*CW-1:CW];
      ay_r <= vq_r[CW-1:0];
    end
    if (state_r == S_SETUP) begin
      bx_r   <= bx;
      by_r   <= by;
      xmaj_r <= xmaj;
      sgnx_r <= dx[CW];
      sgny_r <= dy[CW];
      maj_r  <= maj;
      cx_r   <= $signed(AW'({ax_r, FRAC_BITS'(0)}));
      cy_r   <= $signed(AW'({ay_r, FRAC_BITS'(0)}));
    end
    if (state_r == S_DIV && div_done) begin
      sx_r <= xmaj_r ? (sgnx_r ? -mstep : mstep) : (sgnx_r ? -qstep : qstep);
      sy_r <= xmaj_r ? (sgny_r ? -qstep : qstep) : (sgny_r ? -mstep : mstep);
    end
    if (state_r == S_WALK) begin
      cx_r <= cx_r + sx_r;
      cy_r <= cy_r + sy_r;
      if (cnt_r == '0) begin
        ax_r <= bx_r;
        ay_r <= by_r;
      end
    end
    if (state_r == S_IDLE && in_acc && in_action == ACT_SPAN && ready_r) begin
      pend_row_r  <= cur_row_r;
      pend_last_r <= cur_row_r >= high_r;
    end
    if (pend_r) begin
      out_row_r   <= pend_row_r;
      out_left_r  <= q_left;
      out_right_r <= q_right;
      out_last_r  <= pend_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row_y    = out_row_r;
  assign out_left_x   = out_left_r;
  assign out_right_x  = out_right_r;
  assign out_last_row = out_last_r;

  a_pend_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("span read did not reach the output register");

  a_no_spans_while_building: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !ready_r)
    else $error("spans marked ready during edge walk");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (low_r <= high_r && cur_row_r >= low_r && cur_row_r <= high_r))
    else $error("span row pointer out of polygon rows");

endmodule
